// File: rtl/clu_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the cluster blend skinning block.
// No dependencies; every other file refers to it by scoped names.
package clu_pkg;

	localparam int CLUSTERS   = 256;
	localparam int INFLUENCES = 4;
	localparam int TAB_AW     = $clog2(CLUSTERS);
	localparam int KW         = (INFLUENCES > 1) ? $clog2(INFLUENCES) : 1;

	// rotate unit datapath widths
	localparam int QW        = 17;   // quaternion component, room for negated -2.0
	localparam int VW        = 29;   // vector component into the rotate unit
	localparam int TW        = 47;   // t = 2 * (q x v)
	localparam int CW        = 64;   // q x t and w * t
	localparam int SW        = 66;   // full rotate sum
	localparam int ROT_SHIFT = 28;
	localparam int RW        = SW - ROT_SHIFT;

	localparam int ACC_W        = 58;
	localparam int WEIGHT_SHIFT = 15;
	localparam int SCALE_SHIFT  = 8;
	localparam int SCL_W        = RW + 17;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_SKIN = 1'b1;

	localparam int CFG_IW = 3;
	typedef enum logic [CFG_IW-1:0] {
		REG_ROTATION = 3'd0,
		REG_OFFSET_X = 3'd1,
		REG_OFFSET_Y = 3'd2,
		REG_OFFSET_Z = 3'd3,
		REG_INV_SCALE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  cluster_slot;
		logic [63:0] cluster_rotation;
		logic [59:0] cluster_translation;
		logic [59:0] cluster_rest_center;
		logic [59:0] vertex_position;
		logic [47:0] vertex_normal;
		logic [47:0] vertex_tangent;
		logic [31:0] influence_clusters;
		logic [63:0] influence_weights;
		logic [3:0]  influence_valid;
	} item_t;

	typedef struct packed {
		logic [59:0] skinned_position;
		logic [47:0] skinned_normal;
		logic [47:0] skinned_tangent;
		logic        saturated;
	} result_t;

	typedef struct packed {
		logic [63:0] rot;
		logic [59:0] trans;
		logic [59:0] rest;
	} entry_t;

	typedef logic [3:0][QW-1:0] quat_t;
	typedef logic [2:0][VW-1:0] vec_t;
	typedef logic [2:0][RW-1:0] rvec_t;

endpackage

// File: rtl/clu_table.sv
`timescale 1ns / 1ps
// Cluster table: one synchronous memory holding rotation, translation and
// rest centre per cluster. Depends on clu_pkg.
module clu_table (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [clu_pkg::TAB_AW-1:0] wr_addr,
	input  clu_pkg::entry_t           wr_data,
	input  logic                      rd_en,
	input  logic [clu_pkg::TAB_AW-1:0] rd_addr,
	output clu_pkg::entry_t           rd_data
);

	clu_pkg::entry_t mem [clu_pkg::CLUSTERS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/clu_rotate.sv
`timescale 1ns / 1ps
// Shared quaternion rotate unit: v' = v + w*t + q.xyz x t, t = 2*(q.xyz x v).
// Registers q and v at start, then t, then q.xyz x t and w*t, then the sum. Depends on clu_pkg.
module clu_rotate (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  clu_pkg::quat_t       q,
	input  clu_pkg::vec_t        v,
	output logic                 done,
	output clu_pkg::rvec_t       r
);

	typedef enum logic [1:0] {R_IDLE, R_T, R_C, R_SUM} rstate_t;

	localparam logic signed [clu_pkg::SW-1:0] ROT_HALF =
		clu_pkg::SW'(1) <<< (clu_pkg::ROT_SHIFT - 1);

	rstate_t                       state_q;
	clu_pkg::quat_t                q_q;
	clu_pkg::vec_t                 v_q;
	logic signed [clu_pkg::TW-1:0] t_q  [3];
	logic signed [clu_pkg::CW-1:0] c_q  [3];
	logic signed [clu_pkg::CW-1:0] wt_q [3];

	logic signed [clu_pkg::TW-1:0] t_d  [3];
	logic signed [clu_pkg::CW-1:0] c_d  [3];
	logic signed [clu_pkg::CW-1:0] wt_d [3];
	logic signed [clu_pkg::SW-1:0] s_d  [3];

	always_comb begin
		logic signed [clu_pkg::QW-1:0] qx, qy, qz, qw;
		logic signed [clu_pkg::VW-1:0] vx, vy, vz;
		qx = q_q[0];
		qy = q_q[1];
		qz = q_q[2];
		qw = q_q[3];
		vx = v_q[0];
		vy = v_q[1];
		vz = v_q[2];
		t_d[0] = (qy * vz - qz * vy) <<< 1;
		t_d[1] = (qz * vx - qx * vz) <<< 1;
		t_d[2] = (qx * vy - qy * vx) <<< 1;
		c_d[0] = qy * t_q[2] - qz * t_q[1];
		c_d[1] = qz * t_q[0] - qx * t_q[2];
		c_d[2] = qx * t_q[1] - qy * t_q[0];
		for (int i = 0; i < 3; i++) begin
			wt_d[i] = qw * t_q[i];
		end
		s_d[0] = (clu_pkg::SW'(vx) <<< clu_pkg::ROT_SHIFT) + wt_q[0] + c_q[0] + ROT_HALF;
		s_d[1] = (clu_pkg::SW'(vy) <<< clu_pkg::ROT_SHIFT) + wt_q[1] + c_q[1] + ROT_HALF;
		s_d[2] = (clu_pkg::SW'(vz) <<< clu_pkg::ROT_SHIFT) + wt_q[2] + c_q[2] + ROT_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (start) begin
						q_q     <= q;
						v_q     <= v;
						state_q <= R_T;
					end
				end
				R_T: begin
					t_q     <= t_d;
					state_q <= R_C;
				end
				R_C: begin
					c_q     <= c_d;
					wt_q    <= wt_d;
					state_q <= R_SUM;
				end
				R_SUM: begin
					for (int i = 0; i < 3; i++) begin
						r[i] <= s_d[i][clu_pkg::SW-1:clu_pkg::ROT_SHIFT];
					end
					done    <= 1'b1;
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/cluster_blend_skinning.sv
`timescale 1ns / 1ps
// Top level of the cluster blend skinning block: sequencer, config registers,
// result register. Depends on clu_pkg, clu_table, clu_rotate.
//
//  channel | direction | handshake                  | payload
//  item    | in        | item_valid / item_ready    | item (clu_pkg::item_t)
//  result  | out       | result_valid / result_ready| result (clu_pkg::result_t)
//  cfg     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A load transaction's table write happens at acceptance. A skin transaction
// walks its influences in order: each valid influence takes one table read,
// then three rotations on the shared rotate unit; a skipped influence only
// advances the index. Then come the inverse component transform and the
// write-out, and the next transaction is taken once the write-out is done.
// Reset clears control state and presets the config registers; table contents stay undefined until loaded.
// A stalled result holds in its register; loads are still taken while the sequencer is idle,
// and a following skin transaction waits only at its final write-out.
module cluster_blend_skinning (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  clu_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output clu_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [clu_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [63:0]                 cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE, S_INF, S_VEC, S_ROTW, S_FIN, S_CROT, S_CROTW, S_PACK
	} state_t;

	localparam logic [1:0] VEC_POS = 2'd0;
	localparam logic [1:0] VEC_NRM = 2'd1;
	localparam logic [1:0] VEC_TAN = 2'd2;

	localparam int RND_W = clu_pkg::ACC_W - clu_pkg::WEIGHT_SHIFT;
	localparam int DW    = RND_W + 1;
	localparam int PR_W  = clu_pkg::SCL_W - clu_pkg::SCALE_SHIFT;
	localparam int RW_P1 = clu_pkg::RW + 1;

	localparam logic signed [clu_pkg::ACC_W-1:0] W_HALF =
		clu_pkg::ACC_W'(1) <<< (clu_pkg::WEIGHT_SHIFT - 1);
	localparam logic signed [clu_pkg::SCL_W-1:0] S_HALF =
		clu_pkg::SCL_W'(1) <<< (clu_pkg::SCALE_SHIFT - 1);
	localparam logic signed [DW-1:0]    PRE_HI = DW'(134217728);
	localparam logic signed [DW-1:0]    PRE_LO = -DW'(134217728);
	localparam logic signed [RND_W-1:0] DIR_HI = RND_W'(32767);
	localparam logic signed [RND_W-1:0] DIR_LO = -RND_W'(32768);
	localparam logic signed [PR_W-1:0]  POS_HI = PR_W'(524287);
	localparam logic signed [PR_W-1:0]  POS_LO = -PR_W'(524288);

	state_t                   state_q;
	clu_pkg::item_t           item_q;
	logic [clu_pkg::KW-1:0]   k_q;
	logic [1:0]               j_q;
	logic                     flag_q;
	logic signed [clu_pkg::ACC_W-1:0] acc_q [3][3];
	clu_pkg::vec_t            loc_q;
	logic [47:0]              nrm_q;
	logic [47:0]              tan_q;
	logic signed [clu_pkg::SCL_W-1:0] scl_q [3];

	logic [63:0]              rot_cfg_q;
	logic [19:0]              off_q [3];
	logic [15:0]              inv_q;

	logic                     res_valid_q;
	clu_pkg::result_t         res_q;

	// table and rotate unit hookup
	clu_pkg::entry_t          tab_rd;
	clu_pkg::entry_t          tab_wr;
	logic                     tab_wr_en;
	logic                     tab_rd_en;
	logic [7:0]               cur_idx;
	logic [15:0]              cur_w;
	logic                     cur_vld;
	logic                     cur_use;
	logic                     k_last;
	logic                     rot_start;
	logic                     rot_done;
	clu_pkg::quat_t           rot_qin;
	clu_pkg::vec_t            rot_vin;
	clu_pkg::rvec_t           rot_r;

	logic signed [RW_P1+16:0] prod_d [3];
	clu_pkg::vec_t            loc_d;
	logic [47:0]              nrm_d;
	logic [47:0]              tan_d;
	logic                     fin_flag;
	logic [59:0]              pos_d;
	logic                     pos_flag;

	assign item_ready   = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Write the table straight from the accepted load transaction.
	assign tab_wr_en = item_valid && item_ready && (item.action == clu_pkg::ACT_LOAD)
		&& (int'(item.cluster_slot) < clu_pkg::CLUSTERS);
	assign tab_wr    = '{rot: item.cluster_rotation, trans: item.cluster_translation,
		rest: item.cluster_rest_center};

	assign cur_idx   = item_q.influence_clusters[8*k_q +: 8];
	assign cur_w     = item_q.influence_weights[16*k_q +: 16];
	assign cur_vld   = item_q.influence_valid[k_q];
	assign cur_use   = cur_vld && (int'(cur_idx) < clu_pkg::CLUSTERS);
	assign k_last    = (k_q == clu_pkg::KW'(clu_pkg::INFLUENCES - 1));
	assign tab_rd_en = (state_q == S_INF) && cur_use;
	assign rot_start = (state_q == S_VEC) || (state_q == S_CROT);

	clu_table u_table (
		.clk     (clk),
		.wr_en   (tab_wr_en),
		.wr_addr (clu_pkg::TAB_AW'(item.cluster_slot)),
		.wr_data (tab_wr),
		.rd_en   (tab_rd_en),
		.rd_addr (clu_pkg::TAB_AW'(cur_idx)),
		.rd_data (tab_rd)
	);

	clu_rotate u_rotate (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start),
		.q      (rot_qin),
		.v      (rot_vin),
		.done   (rot_done),
		.r      (rot_r)
	);

	// Select rotate operands, form weighted products and the final clips.
	always_comb begin
		clu_pkg::quat_t                   eq;
		clu_pkg::quat_t                   cq;
		clu_pkg::vec_t                    lv;
		clu_pkg::vec_t                    nv;
		clu_pkg::vec_t                    tv;
		logic signed [16:0]               ws;
		logic signed [clu_pkg::RW-1:0]    rr;
		logic signed [RW_P1-1:0]          bsum;
		logic signed [clu_pkg::ACC_W-1:0] rs;
		logic signed [RND_W-1:0]          rv;
		logic signed [DW-1:0]             d;
		logic signed [clu_pkg::SCL_W-1:0] ps;
		logic signed [PR_W-1:0]           pr;
		for (int i = 0; i < 4; i++) begin
			eq[i] = clu_pkg::QW'($signed(tab_rd.rot[16*i +: 16]));
		end
		for (int i = 0; i < 3; i++) begin
			cq[i] = -clu_pkg::QW'($signed(rot_cfg_q[16*i +: 16]));
		end
		cq[3] = clu_pkg::QW'($signed(rot_cfg_q[63:48]));
		for (int i = 0; i < 3; i++) begin
			lv[i] = clu_pkg::VW'($signed(item_q.vertex_position[20*i +: 20]))
				- clu_pkg::VW'($signed(tab_rd.rest[20*i +: 20]));
			nv[i] = clu_pkg::VW'($signed(item_q.vertex_normal[16*i +: 16]));
			tv[i] = clu_pkg::VW'($signed(item_q.vertex_tangent[16*i +: 16]));
		end
		case (state_q)
			S_CROT: begin
				rot_qin = cq;
				rot_vin = loc_q;
			end
			default: begin
				rot_qin = eq;
				case (j_q)
					VEC_POS: rot_vin = lv;
					VEC_NRM: rot_vin = nv;
					default: rot_vin = tv;
				endcase
			end
		endcase

		ws = $signed({1'b0, cur_w});
		for (int i = 0; i < 3; i++) begin
			rr   = rot_r[i];
			bsum = RW_P1'(rr);
			if (j_q == VEC_POS) begin
				bsum = bsum + RW_P1'($signed(tab_rd.trans[20*i +: 20]));
			end
			prod_d[i] = bsum * ws;
		end

		fin_flag = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rs = acc_q[VEC_POS][i] + W_HALF;
			rv = rs[clu_pkg::ACC_W-1:clu_pkg::WEIGHT_SHIFT];
			d  = DW'(rv) - DW'($signed(off_q[i]));
			if (d > PRE_HI) begin
				d = PRE_HI;
				fin_flag = 1'b1;
			end else if (d < PRE_LO) begin
				d = PRE_LO;
				fin_flag = 1'b1;
			end
			loc_d[i] = clu_pkg::VW'(d);

			rs = acc_q[VEC_NRM][i] + W_HALF;
			rv = rs[clu_pkg::ACC_W-1:clu_pkg::WEIGHT_SHIFT];
			if (rv > DIR_HI) begin
				rv = DIR_HI;
				fin_flag = 1'b1;
			end else if (rv < DIR_LO) begin
				rv = DIR_LO;
				fin_flag = 1'b1;
			end
			nrm_d[16*i +: 16] = rv[15:0];

			rs = acc_q[VEC_TAN][i] + W_HALF;
			rv = rs[clu_pkg::ACC_W-1:clu_pkg::WEIGHT_SHIFT];
			if (rv > DIR_HI) begin
				rv = DIR_HI;
				fin_flag = 1'b1;
			end else if (rv < DIR_LO) begin
				rv = DIR_LO;
				fin_flag = 1'b1;
			end
			tan_d[16*i +: 16] = rv[15:0];
		end

		pos_flag = 1'b0;
		for (int i = 0; i < 3; i++) begin
			ps = scl_q[i] + S_HALF;
			pr = ps[clu_pkg::SCL_W-1:clu_pkg::SCALE_SHIFT];
			if (pr > POS_HI) begin
				pr = POS_HI;
				pos_flag = 1'b1;
			end else if (pr < POS_LO) begin
				pr = POS_LO;
				pos_flag = 1'b1;
			end
			pos_d[20*i +: 20] = pr[19:0];
		end
	end

	// Configuration registers: a write is taken in any cycle; senders must issue
	// writes only while no skin transaction is in flight; the block leaves this to them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_cfg_q <= 64'h4000_0000_0000_0000;
			off_q[0]  <= '0;
			off_q[1]  <= '0;
			off_q[2]  <= '0;
			inv_q     <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				clu_pkg::REG_ROTATION:  rot_cfg_q <= cfg_data;
				clu_pkg::REG_OFFSET_X:  off_q[0]  <= cfg_data[19:0];
				clu_pkg::REG_OFFSET_Y:  off_q[1]  <= cfg_data[19:0];
				clu_pkg::REG_OFFSET_Z:  off_q[2]  <= cfg_data[19:0];
				clu_pkg::REG_INV_SCALE: inv_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer: walk influences, three rotations per valid one, then the inverse
	// component transform and the write-out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			k_q         <= '0;
			j_q         <= VEC_POS;
			flag_q      <= 1'b0;
		end else begin
			// drop the result once taken, unless the write-out refills it now
			if (res_valid_q && result_ready && (state_q != S_PACK)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid && item.action == clu_pkg::ACT_SKIN) begin
						item_q <= item;
						k_q    <= '0;
						j_q    <= VEC_POS;
						flag_q <= 1'b0;
						for (int a = 0; a < 3; a++) begin
							for (int b = 0; b < 3; b++) begin
								acc_q[a][b] <= '0;
							end
						end
						state_q <= S_INF;
					end
				end
				S_INF: begin
					if (cur_use) begin
						state_q <= S_VEC;
					end else if (k_last) begin
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_VEC: state_q <= S_ROTW;
				S_ROTW: begin
					if (rot_done) begin
						for (int i = 0; i < 3; i++) begin
							acc_q[j_q][i] <= acc_q[j_q][i] + clu_pkg::ACC_W'(prod_d[i]);
						end
						if (j_q == VEC_TAN) begin
							j_q <= VEC_POS;
							if (k_last) begin
								state_q <= S_FIN;
							end else begin
								k_q     <= k_q + 1'b1;
								state_q <= S_INF;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_VEC;
						end
					end
				end
				S_FIN: begin
					loc_q   <= loc_d;
					nrm_q   <= nrm_d;
					tan_q   <= tan_d;
					flag_q  <= fin_flag;
					state_q <= S_CROT;
				end
				S_CROT: state_q <= S_CROTW;
				S_CROTW: begin
					if (rot_done) begin
						for (int i = 0; i < 3; i++) begin
							scl_q[i] <= $signed(rot_r[i]) * $signed({1'b0, inv_q});
						end
						state_q <= S_PACK;
					end
				end
				S_PACK: begin
					// hold until the result register is free
					if (!res_valid_q || result_ready) begin
						res_q.skinned_position <= pos_d;
						res_q.skinned_normal   <= nrm_q;
						res_q.skinned_tangent  <= tan_q;
						res_q.saturated        <= flag_q | pos_flag;
						res_valid_q            <= 1'b1;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/clu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for cluster_blend_skinning, bound to the top level.
// Depends on clu_pkg and the top level's port names.
module clu_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input clu_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_ready,
	input clu_pkg::result_t result
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result changed while stalled");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.action == clu_pkg::ACT_LOAD && !result_valid
		|=> !result_valid)
		else $error("load transaction produced a result");

	a_skin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.action == clu_pkg::ACT_SKIN |=> !item_ready)
		else $error("skin transaction did not occupy the block");

endmodule

bind cluster_blend_skinning clu_checker u_clu_checker (.*);

// File: verif/tb_cluster_blend_skinning.sv
`timescale 1ns / 1ps
// Self-checking testbench for cluster_blend_skinning: random and directed load/skin traffic.
// Depends on clu_pkg and the cluster_blend_skinning RTL; holds its own skinning predictor.
module tb_cluster_blend_skinning;

	typedef logic signed [127:0] wide_t;

	localparam int IDLE_LIMIT = 8000;   // cycles with no transaction before giving up
	localparam int TAIL_WAIT  = 120;    // extra wait after the last expected result of a phase

	// Skinning predictor and result store. Tables and registers mirror the block.
	class skin_scoreboard;
		logic [63:0] rot_tab[clu_pkg::CLUSTERS];
		logic [59:0] trans_tab[clu_pkg::CLUSTERS];
		logic [59:0] rest_tab[clu_pkg::CLUSTERS];
		logic [63:0] comp_rot;
		logic [19:0] comp_off[3];
		logic [15:0] inv_scale;
		clu_pkg::result_t pending_results[$];
		int          errors;

		function new();
			comp_rot = 64'h4000_0000_0000_0000;
			foreach (comp_off[i]) comp_off[i] = '0;
			inv_scale = 16'd256;
			errors = 0;
		endfunction

		function void set_reg(clu_pkg::cfg_reg_t idx, logic [63:0] data);
			case (idx)
				clu_pkg::REG_ROTATION: begin
					comp_rot = data;
				end
				clu_pkg::REG_OFFSET_X: begin
					comp_off[0] = data[19:0];
				end
				clu_pkg::REG_OFFSET_Y: begin
					comp_off[1] = data[19:0];
				end
				clu_pkg::REG_OFFSET_Z: begin
					comp_off[2] = data[19:0];
				end
				clu_pkg::REG_INV_SCALE: begin
					inv_scale = data[15:0];
				end
				default: begin
				end
			endcase
		endfunction

		// sign-extend the field of width bits found at the bottom of v
		function wide_t sx(logic [63:0] v, int bits);
			wide_t r;
			r = wide_t'(v);
			r = (r <<< (128 - bits)) >>> (128 - bits);
			return r;
		endfunction

		function wide_t round_sh(wide_t x, int s);
			return (x + (wide_t'(1) <<< (s - 1))) >>> s;
		endfunction

		function wide_t clip(wide_t x, wide_t lo, wide_t hi, inout bit flag);
			if (x < lo) begin
				flag = 1'b1;
				return lo;
			end
			if (x > hi) begin
				flag = 1'b1;
				return hi;
			end
			return x;
		endfunction

		function logic [63:0] pack3(wide_t v[3], int bits, inout bit flag);
			logic [63:0] pk;
			wide_t hi;
			wide_t c;
			pk = '0;
			hi = (wide_t'(1) <<< (bits - 1)) - 1;
			for (int i = 0; i < 3; i++) begin
				c = clip(v[i], -hi - 1, hi, flag);
				pk = pk | ((c[63:0] & ((64'd1 << bits) - 1)) << (bits * i));
			end
			return pk;
		endfunction

		function void unpack3(logic [63:0] p, int bits, output wide_t v[3]);
			for (int i = 0; i < 3; i++) v[i] = sx(p >> (bits * i), bits);
		endfunction

		function void unpack_quat(logic [63:0] p, output wide_t q[4]);
			for (int i = 0; i < 4; i++) q[i] = sx(p >> (16 * i), 16);
		endfunction

		// v' = v + w*t + q.xyz x t with t = 2*(q.xyz x v), kept at the scale of v
		function void quat_rotate(wide_t q[4], wide_t v[3], output wide_t r[3]);
			wide_t t[3];
			wide_t c[3];
			t[0] = 2 * (q[1] * v[2] - q[2] * v[1]);
			t[1] = 2 * (q[2] * v[0] - q[0] * v[2]);
			t[2] = 2 * (q[0] * v[1] - q[1] * v[0]);
			c[0] = q[1] * t[2] - q[2] * t[1];
			c[1] = q[2] * t[0] - q[0] * t[2];
			c[2] = q[0] * t[1] - q[1] * t[0];
			for (int i = 0; i < 3; i++)
				r[i] = round_sh((v[i] <<< clu_pkg::ROT_SHIFT) + q[3] * t[i] + c[i],
					clu_pkg::ROT_SHIFT);
		endfunction

		// Note an accepted item: update the tables, or predict a skinned vertex.
		function void note_item(clu_pkg::item_t it);
			wide_t pos[3], nrm[3], tng[3], sp[3], sn[3], st[3];
			wide_t q[4], tr[3], rc[3], lv[3], r[3], cq[4];
			wide_t w;
			logic [7:0] idx;
			bit flag;
			clu_pkg::result_t res;
			if (it.action == clu_pkg::ACT_LOAD) begin
				rot_tab[it.cluster_slot]   = it.cluster_rotation;
				trans_tab[it.cluster_slot] = it.cluster_translation;
				rest_tab[it.cluster_slot]  = it.cluster_rest_center;
				return;
			end
			flag = 1'b0;
			unpack3(it.vertex_position, 20, pos);
			unpack3(it.vertex_normal, 16, nrm);
			unpack3(it.vertex_tangent, 16, tng);
			for (int i = 0; i < 3; i++) begin
				sp[i] = 0;
				sn[i] = 0;
				st[i] = 0;
			end
			for (int k = 0; k < clu_pkg::INFLUENCES; k++) begin
				idx = it.influence_clusters[8*k +: 8];
				w = wide_t'(it.influence_weights[16*k +: 16]);
				if (!it.influence_valid[k] || idx >= clu_pkg::CLUSTERS) continue;
				unpack_quat(rot_tab[idx], q);
				unpack3(trans_tab[idx], 20, tr);
				unpack3(rest_tab[idx], 20, rc);
				for (int i = 0; i < 3; i++) lv[i] = pos[i] - rc[i];
				quat_rotate(q, lv, r);
				for (int i = 0; i < 3; i++) sp[i] += (r[i] + tr[i]) * w;
				quat_rotate(q, nrm, r);
				for (int i = 0; i < 3; i++) sn[i] += r[i] * w;
				quat_rotate(q, tng, r);
				for (int i = 0; i < 3; i++) st[i] += r[i] * w;
			end
			for (int i = 0; i < 3; i++) begin
				sp[i] = round_sh(sp[i], clu_pkg::WEIGHT_SHIFT);
				sn[i] = round_sh(sn[i], clu_pkg::WEIGHT_SHIFT);
				st[i] = round_sh(st[i], clu_pkg::WEIGHT_SHIFT);
				// pre-rotation clip to +-2^27
				lv[i] = clip(sp[i] - sx(comp_off[i], 20), -134217728, 134217728, flag);
			end
			unpack_quat(comp_rot, cq);
			for (int i = 0; i < 3; i++) cq[i] = -cq[i];
			quat_rotate(cq, lv, r);
			for (int i = 0; i < 3; i++)
				r[i] = round_sh(r[i] * wide_t'(inv_scale), clu_pkg::SCALE_SHIFT);
			res.skinned_position = pack3(r, 20, flag);
			res.skinned_normal   = pack3(sn, 16, flag);
			res.skinned_tangent  = pack3(st, 16, flag);
			res.saturated        = flag;
			pending_results.push_back(res);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h expected %h", what, got, want);
			errors++;
		endtask

		task check(clu_pkg::result_t got);
			clu_pkg::result_t want;
			if (pending_results.size() == 0) begin
				report("unexpected result", got.skinned_position, 64'd0);
				return;
			end
			want = pending_results.pop_front();
			if (got.skinned_position !== want.skinned_position)
				report("skinned_position", got.skinned_position, want.skinned_position);
			if (got.skinned_normal !== want.skinned_normal)
				report("skinned_normal", got.skinned_normal, want.skinned_normal);
			if (got.skinned_tangent !== want.skinned_tangent)
				report("skinned_tangent", got.skinned_tangent, want.skinned_tangent);
			if (got.saturated !== want.saturated)
				report("saturated", got.saturated, want.saturated);
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	clu_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	clu_pkg::result_t result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [clu_pkg::CFG_IW-1:0] cfg_index;
	logic [63:0]      cfg_data;

	skin_scoreboard sb;
	int  send_idle_pct;      // chance in percent that the sender skips a cycle
	int  recv_stall_pct;     // chance in percent that the receiver drops ready
	int  hold_left;          // remaining cycles of a forced receiver hold-off
	int  quiet_cycles;
	bit  loaded[clu_pkg::CLUSTERS];   // slots that the stimulus has already loaded
	int  loaded_list[$];

	cluster_blend_skinning u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: drop ready at random, or hold it low for a forced stretch.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: feed accepted transactions to the scoreboard and run the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) sb.note_item(item);
			if (result_valid && result_ready) sb.check(result);
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function logic [63:0] rand_quat();
		if ($urandom_range(3) == 0) return 64'h4000_0000_0000_0000;
		return rand64();
	endfunction

	// Hold valid until the block takes the item; gaps come before the offer.
	task send_item(clu_pkg::item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!(item_valid && item_ready));
	endtask

	task send_load(logic [7:0] slot, logic [63:0] q, logic [59:0] tr, logic [59:0] rc);
		clu_pkg::item_t it;
		logic [511:0]   raw;
		raw = {rand64(), rand64(), rand64(), rand64(),
		       rand64(), rand64(), rand64(), rand64()};
		it = raw[$bits(clu_pkg::item_t)-1:0];
		it.action = clu_pkg::ACT_LOAD;
		it.cluster_slot = slot;
		it.cluster_rotation = q;
		it.cluster_translation = tr;
		it.cluster_rest_center = rc;
		if (!loaded[slot]) begin
			loaded[slot] = 1'b1;
			loaded_list.push_back(slot);
		end
		send_item(it);
	endtask

	// Skin with valid influences only on loaded slots; invalid ones take any index.
	task send_skin(logic [59:0] p, logic [47:0] n, logic [47:0] t, logic [63:0] w,
	               logic [3:0] vld);
		clu_pkg::item_t it;
		logic [511:0]   raw;
		raw = {rand64(), rand64(), rand64(), rand64(),
		       rand64(), rand64(), rand64(), rand64()};
		it = raw[$bits(clu_pkg::item_t)-1:0];
		it.action = clu_pkg::ACT_SKIN;
		it.vertex_position = p;
		it.vertex_normal = n;
		it.vertex_tangent = t;
		it.influence_weights = w;
		it.influence_valid = vld;
		for (int k = 0; k < 4; k++)
			if (vld[k])
				it.influence_clusters[8*k +: 8] =
					8'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
		send_item(it);
	endtask

	task write_reg(clu_pkg::cfg_reg_t idx, logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every expected result, then idle for a tail wait.
	task drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
	endtask

	task random_traffic(int count);
		logic [63:0] w;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 30) begin
				send_load(8'($urandom_range(255)), rand_quat(), 60'(rand64()),
					60'(rand64()));
			end else begin
				case ($urandom_range(2))
					0: w = rand64();
					1: w = {4{16'd8192}};
					default: w = {16'($urandom_range(32768)), 16'($urandom_range(16384)),
					              16'($urandom_range(65535)), 16'($urandom_range(32768))};
				endcase
				send_skin(60'(rand64()), 48'(rand64()), 48'(rand64()), w,
					4'($urandom_range(15)));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = clu_pkg::REG_ROTATION;
		cfg_data = '0;
		hold_left = 0;
		quiet_cycles = 0;
		send_idle_pct = 31;
		recv_stall_pct = 69;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity component transform, unit scale
		write_reg(clu_pkg::REG_ROTATION, 64'h4000_0000_0000_0000);
		write_reg(clu_pkg::REG_OFFSET_X, 64'd0);
		write_reg(clu_pkg::REG_OFFSET_Y, 64'd0);
		write_reg(clu_pkg::REG_OFFSET_Z, 64'd0);
		write_reg(clu_pkg::REG_INV_SCALE, 64'd256);

		// Directed: extreme loads and skins at the corners of every field.
		send_load(8'd0, 64'h4000_0000_0000_0000, 60'd0, 60'd0);
		send_load(8'd255, {64{1'b1}}, {60{1'b1}}, {60{1'b1}});
		send_load(8'd128, 64'h8000_8000_8000_8000, {3{20'h7FFFF}}, {3{20'h80000}});
		send_load(8'd127, 64'h7FFF_7FFF_7FFF_7FFF, {3{20'h80000}}, {3{20'h7FFFF}});
		send_load(8'd85, 64'h4000_0000_0000_0000, {3{20'h00100}}, {3{20'h00200}});
		send_skin({3{20'h00100}}, {3{16'h4000}}, {3{16'hC000}}, 64'h0000_0000_0000_8000, 4'b0001);
		send_skin('0, '0, '0, '0, 4'b0000);                              // no valid influence
		send_skin({60{1'b1}}, {48{1'b1}}, {48{1'b1}}, {64{1'b1}}, 4'b0000);
		send_skin({3{20'h7FFFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {64{1'b1}}, 4'b1111);
		send_skin({3{20'h80000}}, {3{16'h8000}}, {3{16'h8000}}, {64{1'b1}}, 4'b1111);
		send_skin({3{20'h7FFFF}}, {3{16'h8000}}, {3{16'h7FFF}}, {4{16'h8000}}, 4'b1111);
		send_skin({3{20'h80000}}, {3{16'h4000}}, {3{16'h0000}}, {4{16'h2000}}, 4'b1010);
		send_skin(60'(rand64()), 48'(rand64()), 48'(rand64()), {4{16'h2000}}, 4'b0101);
		random_traffic(370);
		drain();

		// Offsets at both ends, largest scale: heavy saturation.
		send_idle_pct = 69;
		recv_stall_pct = 31;
		write_reg(clu_pkg::REG_ROTATION, rand64());
		write_reg(clu_pkg::REG_OFFSET_X, 64'd524287);
		write_reg(clu_pkg::REG_OFFSET_Y, 64'hFFFF_FFFF_FFF8_0000);
		write_reg(clu_pkg::REG_OFFSET_Z, 64'($urandom_range(1048575)));
		write_reg(clu_pkg::REG_INV_SCALE, 64'd65535);
		random_traffic(380);
		drain();

		// Smallest nonzero scale, no idling; a long receiver hold-off fills the block first.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(clu_pkg::REG_ROTATION, rand64());
		write_reg(clu_pkg::REG_OFFSET_X, 64'hFFFF_FFFF_FFF8_0000);
		write_reg(clu_pkg::REG_OFFSET_Y, 64'd524287);
		write_reg(clu_pkg::REG_OFFSET_Z, 64'($urandom_range(1048575)));
		write_reg(clu_pkg::REG_INV_SCALE, 64'd1);
		hold_left = 800;
		random_traffic(380);
		drain();

		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/clu_pkg.sv
rtl/clu_table.sv
rtl/clu_rotate.sv
rtl/cluster_blend_skinning.sv
rtl/clu_checker.sv
verif/tb_cluster_blend_skinning.sv
